@@ rtl/core/rbsn_pkg.sv @@
// Shared constants, types and the saturation helper for the ray-box nearest-hit block.
package rbsn_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS   = 16;
    localparam int MAX_OBJECTS = 1024;
    localparam int VAL_W       = 32;
    localparam int DIFF_W      = VAL_W + 1;
    localparam int DIST_W      = 31;
    localparam int EPS_W       = 16;
    localparam int ID_W        = $clog2(MAX_OBJECTS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int AXES        = 3;
    localparam int AXIS_W      = 2;

    // Reciprocal divider: 2^(2*FRAC_BITS) / |dir|, one quotient bit per cycle.
    localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
    localparam int QUO_W     = DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Slab products: |diff| * |recip|.
    localparam int PROD_W    = DIFF_W + VAL_W;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    localparam int SAT_IN_W  = (SHIFT_W > QUO_W) ? SHIFT_W : QUO_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VAL_W-1:0]    VAL_ONE  = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0]    VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]    VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [DIST_W-1:0]   DIST_MAX = {DIST_W{1'b1}};
    localparam logic [EPS_W-1:0]    EPS_RESET = EPS_W'(1);
    localparam logic [SAT_IN_W-1:0] NEG_LIM  = SAT_IN_W'(1) << (VAL_W - 1);
    localparam logic [SAT_IN_W-1:0] POS_LIM  = NEG_LIM - SAT_IN_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5,
        CFG_MAX_DIST = 3'd6,
        CFG_EPSILON  = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } t_div_state;

    typedef struct packed {
        logic [AXES-1:0][VAL_W-1:0] origin;
        logic [AXES-1:0][VAL_W-1:0] dir;
        logic [DIST_W-1:0]          max_dist;
        logic [EPS_W-1:0]           eps;
    } t_ray;

    // One classified box as it travels through the queue.
    typedef struct packed {
        logic [AXES-1:0][DIFF_W-1:0] diff_lo;
        logic [AXES-1:0][DIFF_W-1:0] diff_hi;
        logic [AXES-1:0]             par;
        logic                        reject;
        logic [ID_W-1:0]             obj_id;
        logic                        skip;
        logic                        last;
    } t_entry;

    typedef struct packed {
        logic [AXES-1:0][PROD_W-1:0] prod_lo;
        logic [AXES-1:0][PROD_W-1:0] prod_hi;
        logic [AXES-1:0]             neg_lo;
        logic [AXES-1:0]             neg_hi;
        logic [AXES-1:0]             par;
        logic                        reject;
        logic [ID_W-1:0]             obj_id;
        logic                        skip;
        logic                        last;
    } t_prod;

    typedef struct packed {
        logic [AXES-1:0][VAL_W-1:0] t_near;
        logic [AXES-1:0][VAL_W-1:0] t_far;
        logic [AXES-1:0]            par;
        logic                       reject;
        logic [ID_W-1:0]            obj_id;
        logic                       skip;
        logic                       last;
    } t_slab;

    // Applies a sign to a magnitude and saturates to a 32-bit signed value.
    function automatic logic [VAL_W-1:0] sat_signed(input logic [SAT_IN_W-1:0] mag,
                                                    input logic neg);
        logic [VAL_W-1:0] res;
        if (neg) begin
            if (mag > NEG_LIM) begin
                res = VAL_MIN;
            end else begin
                res = VAL_W'(~mag[VAL_W-1:0] + VAL_W'(1));
            end
        end else begin
            if (mag > POS_LIM) begin
                res = VAL_MAX;
            end else begin
                res = mag[VAL_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/ray_box_slab_nearest_hit.sv @@
// Top level of the ray versus box slab test with nearest-hit search.
//
// A ray is loaded through the configuration channel (origin and direction in Q16.16,
// maximum distance in unsigned Q15.16, parallel epsilon in unsigned Q0.16), then
// world-space boxes stream in, one transfer per box. The block sustains one box per
// clock cycle: a front stage orders each box's bounds and flags parallel axes, a
// four-entry queue decouples it from a three-stage back end (slab products, distance
// scaling and ordering, interval clipping with the running nearest-hit compare). A box
// passes through the front register, the queue and the two back-end stage registers;
// if it is marked last, its query result is then written into the output register.
// The result register lets the next query's boxes keep flowing while a result waits;
// only a further last box stalls behind an untaken result. After reset all three
// direction reciprocals, and after every write of a direction register that axis's
// reciprocal, are recomputed by a shared bit-serial divider that produces one
// quotient bit per cycle (after reset only the z direction is nonzero, and a zero
// axis gets a zero reciprocal without a division); during that time neither boxes
// nor configuration writes are taken. Exactly one result is given for each box
// marked last, including a skipped last box; with no hit it reports id zero and the
// largest representable distance.
module ray_box_slab_nearest_hit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rbsn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rbsn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Box input channel.
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [rbsn_pkg::VAL_W-1:0]   i_box_min_x,
    input  logic signed [rbsn_pkg::VAL_W-1:0]   i_box_min_y,
    input  logic signed [rbsn_pkg::VAL_W-1:0]   i_box_min_z,
    input  logic signed [rbsn_pkg::VAL_W-1:0]   i_box_max_x,
    input  logic signed [rbsn_pkg::VAL_W-1:0]   i_box_max_y,
    input  logic signed [rbsn_pkg::VAL_W-1:0]   i_box_max_z,
    input  logic [rbsn_pkg::ID_W-1:0]           i_object_id,
    input  logic                                i_skip_box,
    input  logic                                i_last_box,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit_found,
    output logic [rbsn_pkg::ID_W-1:0]           o_nearest_id,
    output logic [rbsn_pkg::DIST_W-1:0]         o_nearest_t
);

    rbsn_pkg::t_ray    ray;
    logic [rbsn_pkg::AXES-1:0][rbsn_pkg::VAL_W-1:0] recip;
    logic              recip_ready;
    logic [rbsn_pkg::AXES-1:0][rbsn_pkg::VAL_W-1:0] box_min, box_max;

    rbsn_pkg::t_entry  front_ent, queue_ent;
    logic              front_valid, queue_ready;
    logic              queue_valid, back_pop;

    assign box_min = {i_box_min_z, i_box_min_y, i_box_min_x};
    assign box_max = {i_box_max_z, i_box_max_y, i_box_max_x};

    // Ray registers and reciprocal divider.
    rbsn_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_ray         (ray),
        .o_recip       (recip),
        .o_recip_ready (recip_ready)
    );

    // Object ids are already below MAX_OBJECTS, so storing them needs no reduction.
    rbsn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_box_min     (box_min),
        .i_box_max     (box_max),
        .i_object_id   (i_object_id),
        .i_skip_box    (i_skip_box),
        .i_last_box    (i_last_box),
        .i_ray         (ray),
        .i_recip_ready (recip_ready),
        .o_ent         (front_ent),
        .o_ent_valid   (front_valid),
        .i_ent_ready   (queue_ready)
    );

    rbsn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (queue_ready),
        .i_push_data  (front_ent),
        .o_pop_valid  (queue_valid),
        .i_pop        (back_pop),
        .o_pop_data   (queue_ent)
    );

    rbsn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ent_valid  (queue_valid),
        .i_ent        (queue_ent),
        .o_pop        (back_pop),
        .i_recip      (recip),
        .i_max_dist   (ray.max_dist),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit_found  (o_hit_found),
        .o_nearest_id (o_nearest_id),
        .o_nearest_t  (o_nearest_t)
    );

endmodule

@@ rtl/core/rbsn_cfg.sv @@
// Configuration registers and the bit-serial reciprocal divider for the ray direction.
module rbsn_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbsn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbsn_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rbsn_pkg::t_ray                    o_ray,
    output logic [rbsn_pkg::AXES-1:0][rbsn_pkg::VAL_W-1:0] o_recip,
    output logic                              o_recip_ready
);

    rbsn_pkg::t_ray                  r_ray, n_ray;
    rbsn_pkg::t_div_state            r_state, n_state;
    logic [rbsn_pkg::AXES-1:0]       r_pend, n_pend;
    logic [rbsn_pkg::AXIS_W-1:0]     r_axis, n_axis;
    logic [rbsn_pkg::VAL_W-1:0]      r_div, n_div;
    logic [rbsn_pkg::VAL_W-1:0]      r_rem, n_rem;
    logic [rbsn_pkg::QUO_W-1:0]      r_quo, n_quo;
    logic [rbsn_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [rbsn_pkg::AXES-1:0][rbsn_pkg::VAL_W-1:0] r_recip, n_recip;

    logic                            busy;
    logic                            cfg_wr;
    logic [rbsn_pkg::AXES-1:0]       dir_wr;
    logic [rbsn_pkg::AXIS_W-1:0]     sel;
    logic [rbsn_pkg::VAL_W-1:0]      sel_dir;
    logic [rbsn_pkg::VAL_W:0]        rem_sh;
    logic                            ge;
    logic [rbsn_pkg::QUO_W-1:0]      quo_next;

    assign busy          = (r_state != rbsn_pkg::DIV_IDLE) || (r_pend != '0);
    assign o_cfg_ready   = !busy;
    assign o_recip_ready = !busy;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign o_ray         = r_ray;
    assign o_recip       = r_recip;

    // Register writes.
    always_comb begin
        n_ray  = r_ray;
        dir_wr = '0;
        if (cfg_wr) begin
            unique case (rbsn_pkg::t_cfg_idx'(i_cfg_index))
                rbsn_pkg::CFG_ORIGIN_X: n_ray.origin[0] = i_cfg_data;
                rbsn_pkg::CFG_ORIGIN_Y: n_ray.origin[1] = i_cfg_data;
                rbsn_pkg::CFG_ORIGIN_Z: n_ray.origin[2] = i_cfg_data;
                rbsn_pkg::CFG_DIR_X: begin
                    n_ray.dir[0] = i_cfg_data;
                    dir_wr[0]    = 1'b1;
                end
                rbsn_pkg::CFG_DIR_Y: begin
                    n_ray.dir[1] = i_cfg_data;
                    dir_wr[1]    = 1'b1;
                end
                rbsn_pkg::CFG_DIR_Z: begin
                    n_ray.dir[2] = i_cfg_data;
                    dir_wr[2]    = 1'b1;
                end
                rbsn_pkg::CFG_MAX_DIST: n_ray.max_dist = i_cfg_data[rbsn_pkg::DIST_W-1:0];
                rbsn_pkg::CFG_EPSILON:  n_ray.eps = i_cfg_data[rbsn_pkg::EPS_W-1:0];
                default: n_ray = r_ray;
            endcase
        end
    end

    // Lowest pending axis is served first.
    always_comb begin
        priority if (r_pend[0]) begin
            sel = rbsn_pkg::AXIS_W'(0);
        end else if (r_pend[1]) begin
            sel = rbsn_pkg::AXIS_W'(1);
        end else begin
            sel = rbsn_pkg::AXIS_W'(2);
        end
    end

    assign sel_dir  = r_ray.dir[sel];
    assign rem_sh   = {r_rem, (r_cnt == '0)};
    assign ge       = rem_sh >= {1'b0, r_div};
    assign quo_next = {r_quo[rbsn_pkg::QUO_W-2:0], ge};

    // Divider sequencer: one restoring step per cycle.
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_axis  = r_axis;
        n_div   = r_div;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_recip = r_recip;
        unique case (r_state)
            rbsn_pkg::DIV_IDLE: begin
                if (r_pend != '0) begin
                    n_pend[sel] = 1'b0;
                    if (sel_dir == '0) begin
                        n_recip[sel] = '0;
                    end else begin
                        n_axis  = sel;
                        n_div   = sel_dir[rbsn_pkg::VAL_W-1] ?
                                  rbsn_pkg::VAL_W'(~sel_dir + rbsn_pkg::VAL_W'(1)) : sel_dir;
                        n_rem   = '0;
                        n_quo   = '0;
                        n_cnt   = '0;
                        n_state = rbsn_pkg::DIV_RUN;
                    end
                end
            end
            rbsn_pkg::DIV_RUN: begin
                n_rem = ge ? rbsn_pkg::VAL_W'(rem_sh - {1'b0, r_div})
                           : rem_sh[rbsn_pkg::VAL_W-1:0];
                n_quo = quo_next;
                n_cnt = r_cnt + rbsn_pkg::DIV_CNT_W'(1);
                if (r_cnt == rbsn_pkg::DIV_CNT_W'(rbsn_pkg::DIV_STEPS - 1)) begin
                    n_recip[r_axis] = rbsn_pkg::sat_signed(
                        rbsn_pkg::SAT_IN_W'(quo_next),
                        r_ray.dir[r_axis][rbsn_pkg::VAL_W-1]);
                    n_state = rbsn_pkg::DIV_IDLE;
                end
            end
            default: n_state = rbsn_pkg::DIV_IDLE;
        endcase
        n_pend = n_pend | dir_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbsn_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.origin   <= '0;
            r_ray.dir      <= {rbsn_pkg::VAL_ONE, {(2*rbsn_pkg::VAL_W){1'b0}}};
            r_ray.max_dist <= rbsn_pkg::DIST_MAX;
            r_ray.eps      <= rbsn_pkg::EPS_RESET;
            r_pend         <= '1;
        end else begin
            r_ray  <= n_ray;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis  <= n_axis;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_recip <= n_recip;
    end

endmodule

@@ rtl/core/rbsn_front.sv @@
// Front end: accepts boxes, orders bounds, flags parallel axes and forms origin offsets.
module rbsn_front (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic [rbsn_pkg::AXES-1:0][rbsn_pkg::VAL_W-1:0]  i_box_min,
    input  logic [rbsn_pkg::AXES-1:0][rbsn_pkg::VAL_W-1:0]  i_box_max,
    input  logic [rbsn_pkg::ID_W-1:0]                       i_object_id,
    input  logic                                            i_skip_box,
    input  logic                                            i_last_box,
    input  rbsn_pkg::t_ray                                  i_ray,
    input  logic                                            i_recip_ready,
    output rbsn_pkg::t_entry                                o_ent,
    output logic                                            o_ent_valid,
    input  logic                                            i_ent_ready
);

    rbsn_pkg::t_entry            r_ent, n_ent;
    logic                        r_valid;
    logic                        accept;
    logic [rbsn_pkg::VAL_W-1:0]  lo, hi, org, dir, dir_mag;
    logic                        outside;

    assign o_ready     = i_recip_ready && (!r_valid || i_ent_ready);
    assign accept      = i_valid && o_ready;
    assign o_ent       = r_ent;
    assign o_ent_valid = r_valid;

    always_comb begin
        n_ent        = r_ent;
        n_ent.reject = 1'b0;
        lo           = '0;
        hi           = '0;
        org          = '0;
        dir          = '0;
        dir_mag      = '0;
        outside      = 1'b0;
        for (int a = 0; a < rbsn_pkg::AXES; a++) begin
            if ($signed(i_box_min[a]) > $signed(i_box_max[a])) begin
                lo = i_box_max[a];
                hi = i_box_min[a];
            end else begin
                lo = i_box_min[a];
                hi = i_box_max[a];
            end
            org     = i_ray.origin[a];
            dir     = i_ray.dir[a];
            dir_mag = dir[rbsn_pkg::VAL_W-1] ? rbsn_pkg::VAL_W'(~dir + rbsn_pkg::VAL_W'(1)) : dir;
            n_ent.diff_lo[a] = rbsn_pkg::DIFF_W'($signed(lo)) - rbsn_pkg::DIFF_W'($signed(org));
            n_ent.diff_hi[a] = rbsn_pkg::DIFF_W'($signed(hi)) - rbsn_pkg::DIFF_W'($signed(org));
            n_ent.par[a]     = (dir == '0) ||
                               (dir_mag < rbsn_pkg::VAL_W'(i_ray.eps));
            outside          = ($signed(org) < $signed(lo)) || ($signed(org) > $signed(hi));
            // A parallel axis only rejects; it never narrows the interval.
            n_ent.reject     = n_ent.reject || (n_ent.par[a] && outside);
        end
        n_ent.obj_id = i_object_id;
        n_ent.skip   = i_skip_box;
        n_ent.last   = i_last_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ent_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
        end
    end

endmodule

@@ rtl/core/rbsn_queue.sv @@
// Short queue of classified boxes between the front end and the back end.
module rbsn_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  rbsn_pkg::t_entry  i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop,
    output rbsn_pkg::t_entry  o_pop_data
);

    rbsn_pkg::t_entry             r_mem [rbsn_pkg::QUEUE_DEPTH];
    logic [rbsn_pkg::QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [rbsn_pkg::QCNT_W-1:0]  r_cnt;
    logic                         push, pop;

    assign o_push_ready = r_cnt != rbsn_pkg::QCNT_W'(rbsn_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == rbsn_pkg::QPTR_W'(rbsn_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + rbsn_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == rbsn_pkg::QPTR_W'(rbsn_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + rbsn_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + rbsn_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - rbsn_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rbsn_pkg::QCNT_W'(rbsn_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds its depth");

endmodule

@@ rtl/core/rbsn_back.sv @@
// Back end: slab products, interval clipping, nearest-hit tracking and the result register.
module rbsn_back (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_ent_valid,
    input  rbsn_pkg::t_entry                                i_ent,
    output logic                                            o_pop,
    input  logic [rbsn_pkg::AXES-1:0][rbsn_pkg::VAL_W-1:0]  i_recip,
    input  logic [rbsn_pkg::DIST_W-1:0]                     i_max_dist,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic                                            o_hit_found,
    output logic [rbsn_pkg::ID_W-1:0]                       o_nearest_id,
    output logic [rbsn_pkg::DIST_W-1:0]                     o_nearest_t
);

    rbsn_pkg::t_prod              r_s1, n_s1;
    rbsn_pkg::t_slab              r_s2, n_s2;
    logic                         r_s1_valid, r_s2_valid;
    logic                         r_best_valid;
    logic [rbsn_pkg::DIST_W-1:0]  r_best_dist;
    logic [rbsn_pkg::ID_W-1:0]    r_best_id;
    logic                         r_out_valid, r_out_hit;
    logic [rbsn_pkg::ID_W-1:0]    r_out_id;
    logic [rbsn_pkg::DIST_W-1:0]  r_out_t;

    logic                         stall, fire, fire_last;
    logic [rbsn_pkg::DIFF_W-1:0]  mag_lo, mag_hi;
    logic [rbsn_pkg::VAL_W-1:0]   mag_r, t_a, t_b, lo, hi;
    logic                         hit, better;
    logic                         nb_valid;
    logic [rbsn_pkg::DIST_W-1:0]  nb_dist;
    logic [rbsn_pkg::ID_W-1:0]    nb_id;

    // Only a last box waiting on a full result register holds the pipeline.
    assign stall     = r_s2_valid && r_s2.last && r_out_valid && !i_ready;
    assign fire      = r_s2_valid && !stall;
    assign fire_last = fire && r_s2.last;
    assign o_pop     = !stall;

    // Stage 1: sign-magnitude products of offset and reciprocal.
    always_comb begin
        n_s1   = '0;
        mag_lo = '0;
        mag_hi = '0;
        mag_r  = '0;
        for (int a = 0; a < rbsn_pkg::AXES; a++) begin
            mag_lo = i_ent.diff_lo[a][rbsn_pkg::DIFF_W-1] ?
                     rbsn_pkg::DIFF_W'(~i_ent.diff_lo[a] + rbsn_pkg::DIFF_W'(1)) :
                     i_ent.diff_lo[a];
            mag_hi = i_ent.diff_hi[a][rbsn_pkg::DIFF_W-1] ?
                     rbsn_pkg::DIFF_W'(~i_ent.diff_hi[a] + rbsn_pkg::DIFF_W'(1)) :
                     i_ent.diff_hi[a];
            mag_r  = i_recip[a][rbsn_pkg::VAL_W-1] ?
                     rbsn_pkg::VAL_W'(~i_recip[a] + rbsn_pkg::VAL_W'(1)) : i_recip[a];
            n_s1.prod_lo[a] = rbsn_pkg::PROD_W'(mag_lo) * rbsn_pkg::PROD_W'(mag_r);
            n_s1.prod_hi[a] = rbsn_pkg::PROD_W'(mag_hi) * rbsn_pkg::PROD_W'(mag_r);
            n_s1.neg_lo[a]  = i_ent.diff_lo[a][rbsn_pkg::DIFF_W-1] ^
                              i_recip[a][rbsn_pkg::VAL_W-1];
            n_s1.neg_hi[a]  = i_ent.diff_hi[a][rbsn_pkg::DIFF_W-1] ^
                              i_recip[a][rbsn_pkg::VAL_W-1];
        end
        n_s1.par    = i_ent.par;
        n_s1.reject = i_ent.reject;
        n_s1.obj_id = i_ent.obj_id;
        n_s1.skip   = i_ent.skip;
        n_s1.last   = i_ent.last;
    end

    // Stage 2: scale, saturate and order the two slab distances.
    always_comb begin
        n_s2 = '0;
        t_a  = '0;
        t_b  = '0;
        for (int a = 0; a < rbsn_pkg::AXES; a++) begin
            t_a = rbsn_pkg::sat_signed(
                rbsn_pkg::SAT_IN_W'(r_s1.prod_lo[a] >> rbsn_pkg::FRAC_BITS), r_s1.neg_lo[a]);
            t_b = rbsn_pkg::sat_signed(
                rbsn_pkg::SAT_IN_W'(r_s1.prod_hi[a] >> rbsn_pkg::FRAC_BITS), r_s1.neg_hi[a]);
            if ($signed(t_a) > $signed(t_b)) begin
                n_s2.t_near[a] = t_b;
                n_s2.t_far[a]  = t_a;
            end else begin
                n_s2.t_near[a] = t_a;
                n_s2.t_far[a]  = t_b;
            end
        end
        n_s2.par    = r_s1.par;
        n_s2.reject = r_s1.reject;
        n_s2.obj_id = r_s1.obj_id;
        n_s2.skip   = r_s1.skip;
        n_s2.last   = r_s1.last;
    end

    // Stage 3: clip [0, max distance] and compare with the best hit so far.
    always_comb begin
        lo = '0;
        hi = rbsn_pkg::VAL_W'(i_max_dist);
        for (int a = 0; a < rbsn_pkg::AXES; a++) begin
            if (!r_s2.par[a]) begin
                if ($signed(r_s2.t_near[a]) > $signed(lo)) begin
                    lo = r_s2.t_near[a];
                end
                if ($signed(r_s2.t_far[a]) < $signed(hi)) begin
                    hi = r_s2.t_far[a];
                end
            end
        end
        hit      = !r_s2.skip && !r_s2.reject && ($signed(lo) <= $signed(hi));
        // Strict less-than keeps the earlier box on a tie.
        better   = hit && (!r_best_valid ||
                           ($signed(lo) < $signed({1'b0, r_best_dist})));
        nb_valid = r_best_valid || hit;
        nb_dist  = better ? lo[rbsn_pkg::DIST_W-1:0] : r_best_dist;
        nb_id    = better ? r_s2.obj_id : r_best_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (!stall) begin
                r_s1_valid <= i_ent_valid;
                r_s2_valid <= r_s1_valid;
            end
            if (fire) begin
                r_best_valid <= fire_last ? 1'b0 : nb_valid;
            end
            if (fire_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
        if (fire) begin
            r_best_dist <= nb_dist;
            r_best_id   <= nb_id;
        end
        if (fire_last) begin
            r_out_hit <= nb_valid;
            r_out_id  <= nb_valid ? nb_id : '0;
            r_out_t   <= nb_valid ? nb_dist : rbsn_pkg::DIST_MAX;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit_found  = r_out_hit;
    assign o_nearest_id = r_out_id;
    assign o_nearest_t  = r_out_t;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid && r_s2.last))
        else $error("result raised without a last box");

    a_search_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_last |=> !r_best_valid)
        else $error("search state not cleared after a result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_t) && $stable(r_out_id)))
        else $error("pending result changed before its transfer");

    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stall && r_s1_valid) |=> r_s1_valid && r_s2_valid)
        else $error("pipeline lost a box while stalled");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the ray versus box slab test with nearest-hit search.
module testbench;
    import rbsn_pkg::*;

    localparam int     CYCLE_LIMIT   = 200000;
    // Covers the front stage, the four-entry queue and the three back-end stages.
    localparam int     SETTLE_CYCLES = 16;
    localparam int     RANDOM_BOXES  = 500;
    localparam longint Q_ONE         = 64'sd65536;
    localparam longint T_POS         = 64'sd2147483647;
    localparam longint T_NEG         = -64'sd2147483648;

    typedef struct packed {
        logic [AXES-1:0][VAL_W-1:0] lo;
        logic [AXES-1:0][VAL_W-1:0] hi;
        logic [ID_W-1:0]            obj;
        logic                       skip;
        logic                       last;
    } t_box;

    typedef struct packed {
        logic              hit;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_answer;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        i_valid;
    logic                        o_ready;
    logic signed [VAL_W-1:0]     i_box_min_x;
    logic signed [VAL_W-1:0]     i_box_min_y;
    logic signed [VAL_W-1:0]     i_box_min_z;
    logic signed [VAL_W-1:0]     i_box_max_x;
    logic signed [VAL_W-1:0]     i_box_max_y;
    logic signed [VAL_W-1:0]     i_box_max_z;
    logic [ID_W-1:0]             i_object_id;
    logic                        i_skip_box;
    logic                        i_last_box;
    logic                        o_valid;
    logic                        i_ready;
    logic                        o_hit_found;
    logic [ID_W-1:0]             o_nearest_id;
    logic [DIST_W-1:0]           o_nearest_t;

    ray_box_slab_nearest_hit dut (.*);

    // Ray as the block should hold it, plus the running nearest-hit search.
    longint          ray_o [AXES];
    longint          ray_d [AXES];
    longint          ray_inv [AXES];
    longint          ray_tmax;
    longint          ray_eps;
    longint          near_t;
    logic [ID_W-1:0] near_id;
    bit              near_valid;

    t_answer query_answers [$];
    int      mismatches  = 0;
    int      cycle_count = 0;
    int      boxes_sent  = 0;
    bit      tx_gap_on   = 1'b1;
    bit      rx_stall_on = 1'b1;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
            @(posedge i_clk);
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fixed-point slab arithmetic.
    // ------------------------------------------------------------------
    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Applies a sign and clamps to the 32-bit signed range.
    function automatic longint clamp_signed(input longint unsigned mag, input bit neg);
        if (neg) begin
            return (mag > 64'd2147483648) ? T_NEG : -longint'(mag);
        end
        return (mag > 64'd2147483647) ? T_POS : longint'(mag);
    endfunction

    // Truncated 2^(2*FRAC_BITS) / dir; a zero direction has no reciprocal.
    function automatic longint axis_recip(input longint d);
        if (d == 0) begin
            return 0;
        end
        return clamp_signed((64'd1 << (2 * FRAC_BITS)) / magnitude(d), d < 0);
    endfunction

    function automatic longint slab_distance(input longint diff, input longint r);
        return clamp_signed((magnitude(diff) * magnitude(r)) >> FRAC_BITS, (diff < 0) != (r < 0));
    endfunction

    function automatic void clear_nearest();
        near_t     = T_POS;
        near_id    = '0;
        near_valid = 1'b0;
    endfunction

    function automatic void reset_ray_model();
        for (int a = 0; a < AXES; a++) begin
            ray_o[a] = 0;
            ray_d[a] = 0;
        end
        ray_d[2] = Q_ONE;
        ray_tmax = T_POS;
        ray_eps  = 1;
        for (int a = 0; a < AXES; a++) begin
            ray_inv[a] = axis_recip(ray_d[a]);
        end
        clear_nearest();
    endfunction

    function automatic void set_ray_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        int a;
        case (idx)
            CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z: begin
                ray_o[int'(idx) - int'(CFG_ORIGIN_X)] = $signed(data);
            end
            CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z: begin
                a          = int'(idx) - int'(CFG_DIR_X);
                ray_d[a]   = $signed(data);
                ray_inv[a] = axis_recip(ray_d[a]);
            end
            CFG_MAX_DIST: ray_tmax = data[DIST_W-1:0];
            CFG_EPSILON:  ray_eps  = data[EPS_W-1:0];
            default: ;
        endcase
    endfunction

    // Folds one accepted box into the search; a last box closes the query.
    function automatic void track_nearest(input t_box b);
        longint  lo_b;
        longint  hi_b;
        longint  t_a;
        longint  t_b;
        longint  swap_v;
        longint  t_enter;
        longint  t_exit;
        bit      hit;
        t_answer answer;
        if (!b.skip) begin
            t_enter = 0;
            t_exit  = ray_tmax;
            hit     = 1'b1;
            for (int a = 0; a < AXES && hit; a++) begin
                lo_b = $signed(b.lo[a]);
                hi_b = $signed(b.hi[a]);
                if (lo_b > hi_b) begin
                    swap_v = lo_b;
                    lo_b   = hi_b;
                    hi_b   = swap_v;
                end
                if (ray_d[a] == 0 || magnitude(ray_d[a]) < ray_eps) begin
                    // Parallel axis: only the origin's position in the slab matters.
                    hit = !(ray_o[a] < lo_b || ray_o[a] > hi_b);
                end else begin
                    t_a = slab_distance(lo_b - ray_o[a], ray_inv[a]);
                    t_b = slab_distance(hi_b - ray_o[a], ray_inv[a]);
                    if (t_a > t_b) begin
                        swap_v = t_a;
                        t_a    = t_b;
                        t_b    = swap_v;
                    end
                    if (t_a > t_enter) t_enter = t_a;
                    if (t_b < t_exit) t_exit = t_b;
                    hit = (t_enter <= t_exit);
                end
            end
            // Strict less-than keeps the earlier box on a tie.
            if (hit && (!near_valid || t_enter < near_t)) begin
                near_t     = t_enter;
                near_id    = b.obj;
                near_valid = 1'b1;
            end
        end
        if (b.last) begin
            answer.hit      = near_valid;
            answer.id       = near_valid ? near_id : '0;
            answer.distance = near_valid ? DIST_W'(near_t) : DIST_MAX;
            query_answers.push_back(answer);
            clear_nearest();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("cycle %0d: mismatch, %s", cycle_count, what);
        mismatches++;
    endtask

    // After each result transfer the receiver holds off for a random number of
    // cycles, so stalls land both on waiting results and on empty cycles.
    initial begin : result_ready_gen
        int stall;
        i_ready = 1'b0;
        forever begin
            stall = rx_stall_on ? $urandom_range(0, 7) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (query_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result hit=%0d id=%0d t=%08h",
                                          o_hit_found, o_nearest_id, o_nearest_t));
            end else begin
                want = query_answers.pop_front();
                if (o_hit_found !== want.hit) begin
                    report_mismatch($sformatf("hit_found %0b, expected %0b",
                                              o_hit_found, want.hit));
                end
                if (o_nearest_id !== want.id) begin
                    report_mismatch($sformatf("nearest_id %0d, expected %0d",
                                              o_nearest_id, want.id));
                end
                if (o_nearest_t !== want.distance) begin
                    report_mismatch($sformatf("nearest_t %08h, expected %08h",
                                              o_nearest_t, want.distance));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic send_box(input t_box b);
        int gap;
        gap = tx_gap_on ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_box_min_x <= b.lo[0];
        i_box_min_y <= b.lo[1];
        i_box_min_z <= b.lo[2];
        i_box_max_x <= b.hi[0];
        i_box_max_y <= b.hi[1];
        i_box_max_z <= b.hi[2];
        i_object_id <= b.obj;
        i_skip_box  <= b.skip;
        i_last_box  <= b.last;
        do @(posedge i_clk); while (!o_ready);
        track_nearest(b);
        boxes_sent++;
    endtask

    // Holds the sender until every answer is back and trailing boxes are through.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (query_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        set_ray_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes the registers selected in the mask; the block must be idle first.
    task automatic load_ray(input logic [7:0][CFG_DATA_W-1:0] regs, input logic [7:0] mask);
        drain_results();
        for (int r = 0; r < 8; r++) begin
            if (mask[r]) write_reg(t_cfg_idx'(r), regs[r]);
        end
    endtask

    function automatic t_box mk_box(input longint lx, input longint ly, input longint lz,
                                    input longint hx, input longint hy, input longint hz,
                                    input int id, input bit skip, input bit last);
        t_box b;
        b.lo[0] = VAL_W'(lx);
        b.lo[1] = VAL_W'(ly);
        b.lo[2] = VAL_W'(lz);
        b.hi[0] = VAL_W'(hx);
        b.hi[1] = VAL_W'(hy);
        b.hi[2] = VAL_W'(hz);
        b.obj   = ID_W'(id);
        b.skip  = skip;
        b.last  = last;
        return b;
    endfunction

    // A box placed around a random point along the current ray, jittered so
    // that roughly half of them are missed.
    function automatic t_box near_ray_box(input bit last);
        t_box   b;
        longint t;
        longint p;
        longint h;
        longint j;
        t = $urandom_range(0, 60 * 65536);
        for (int a = 0; a < AXES; a++) begin
            p = ray_o[a] + ((ray_d[a] * t) >>> FRAC_BITS);
            h = $urandom_range(1, 5 * 65536);
            j = longint'($urandom_range(0, 4 * 65536)) - 2 * 65536;
            if ($urandom_range(0, 9) == 0) begin
                b.lo[a] = VAL_W'(p + h + j);
                b.hi[a] = VAL_W'(p - h + j);
            end else begin
                b.lo[a] = VAL_W'(p - h + j);
                b.hi[a] = VAL_W'(p + h + j);
            end
        end
        b.obj  = ID_W'($urandom_range(0, 1023));
        b.skip = ($urandom_range(0, 9) == 0);
        b.last = last;
        return b;
    endfunction

    function automatic t_box wild_box(input bit last);
        t_box b;
        for (int a = 0; a < AXES; a++) begin
            b.lo[a] = $urandom();
            b.hi[a] = $urandom();
        end
        b.obj  = ID_W'($urandom_range(0, 1023));
        b.skip = 1'($urandom_range(0, 1));
        b.last = last;
        return b;
    endfunction

    task automatic send_query(input int n_boxes, input int wild_pct);
        for (int i = 0; i < n_boxes; i++) begin
            if ($urandom_range(0, 99) < wild_pct) begin
                send_box(wild_box(i == n_boxes - 1));
            end else begin
                send_box(near_ray_box(i == n_boxes - 1));
            end
        end
    endtask

    // Either a modest ray that the near boxes hit often, or full-range values.
    task automatic random_ray(input bit wild);
        logic [7:0][CFG_DATA_W-1:0] regs;
        logic [7:0]                 mask;
        int                         d;
        for (int a = 0; a < AXES; a++) begin
            regs[int'(CFG_ORIGIN_X) + a] = wild ? $urandom()
                : CFG_DATA_W'(int'($urandom_range(0, 200 * 65536)) - 100 * 65536);
            if (wild) begin
                regs[int'(CFG_DIR_X) + a] = $urandom();
            end else if ($urandom_range(0, 3) == 0) begin
                regs[int'(CFG_DIR_X) + a] = '0;
            end else begin
                d = $urandom_range(1, 4 * 65536);
                if ($urandom_range(0, 1) == 1) d = -d;
                regs[int'(CFG_DIR_X) + a] = CFG_DATA_W'(d);
            end
        end
        case ($urandom_range(0, 3))
            0:       regs[CFG_MAX_DIST] = 32'h7FFF_FFFF;
            1:       regs[CFG_MAX_DIST] = $urandom();
            2:       regs[CFG_MAX_DIST] = $urandom_range(0, 80 * 65536);
            default: regs[CFG_MAX_DIST] = '0;
        endcase
        regs[CFG_EPSILON] = wild ? $urandom() : $urandom_range(0, 300);
        mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
        load_ray(regs, mask);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset ray: origin at zero looking along +z, so x and y are parallel axes.
    task automatic test_default_ray();
        longint q;
        q = Q_ONE;
        send_box(mk_box(-q, -q, 10 * q, q, q, 20 * q, 5, 1'b0, 1'b0));
        send_box(mk_box(-q, -q, 4 * q, q, q, 6 * q, 7, 1'b0, 1'b0));
        // Same entry distance as the previous box: the earlier one must stay.
        send_box(mk_box(-q, -q, 4 * q, q, q, 8 * q, 9, 1'b0, 1'b0));
        // All pairs out of order; entry at 2.0 is the new nearest.
        send_box(mk_box(q, q, 30 * q, -q, -q, 2 * q, 11, 1'b0, 1'b0));
        send_box(mk_box(-q, -q, 0, q, q, q, 12, 1'b1, 1'b0));
        // Origin outside the parallel x slab rejects the box.
        send_box(mk_box(2 * q, -q, 0, 3 * q, q, q, 13, 1'b0, 1'b1));
        send_box(mk_box(-q, -q, -20 * q, q, q, -10 * q, 1, 1'b0, 1'b1));
        // Origin on the x face of a box that contains it.
        send_box(mk_box(0, -q, -q, q, q, q, 1023, 1'b0, 1'b1));
        send_box(mk_box(T_NEG, T_NEG, T_NEG, T_POS, T_POS, T_POS, 0, 1'b0, 1'b1));
        send_box(mk_box(T_POS, T_POS, T_POS, T_NEG, T_NEG, T_NEG, 1022, 1'b0, 1'b0));
        send_box(mk_box(-q, -q, 5 * q, q, q, 5 * q, 3, 1'b0, 1'b1));
        // A query made of a single skipped box reports no hit.
        send_box(mk_box(-q, -q, 5 * q, q, q, 5 * q, 3, 1'b1, 1'b1));
        // Zero-thickness slab: entry equals exit and still counts as a hit.
        send_box(mk_box(-q, -q, 5 * q, q, q, 5 * q, 4, 1'b0, 1'b1));
        send_box(mk_box(-q, -q, 100 * q, q, q, T_POS, 512, 1'b0, 1'b1));
    endtask

    // Register extremes: saturating reciprocals, epsilon at both ends, zero
    // directions with a zero epsilon, and the distance limit at both ends.
    task automatic test_ray_registers();
        logic [7:0][CFG_DATA_W-1:0] regs;
        regs = {32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
        load_ray(regs, 8'hFF);
        send_box(mk_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 21, 1'b0, 1'b0));
        send_query(3, 30);

        regs = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0002, 32'h0000_FFFF, 32'h0000_0000,
                32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        load_ray(regs, 8'hFF);
        send_query(4, 25);

        regs = {32'h0000_0000, 32'h0000_3039, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000};
        load_ray(regs, 8'hFF);
        send_box(mk_box(0, -3 * Q_ONE, 0, 2 * Q_ONE, 0, 4 * Q_ONE, 22, 1'b0, 1'b0));
        send_query(3, 25);

        regs = {32'h0000_0001, 32'h0064_0000, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0000_0000, 32'h0014_0000, 32'hFFCE_0000};
        load_ray(regs, 8'hFF);
        send_query(4, 25);
    endtask

    task automatic test_burst_and_drain();
        tx_gap_on   = 1'b0;
        rx_stall_on = 1'b0;
        repeat (6) send_query($urandom_range(2, 6), 10);
        // Pause in the middle of a query until every answer has come back.
        send_box(near_ray_box(1'b0));
        send_box(near_ray_box(1'b0));
        drain_results();
        send_box(near_ray_box(1'b1));
        // Boxes stream back to back while the result side stalls.
        rx_stall_on = 1'b1;
        repeat (6) send_query($urandom_range(1, 4), 10);
        tx_gap_on = 1'b1;
    endtask

    task automatic test_random_queries();
        int phase;
        int stop_at;
        phase   = 0;
        stop_at = boxes_sent + RANDOM_BOXES;
        while (boxes_sent < stop_at) begin
            random_ray(phase % 4 == 3);
            // Most phases idle on both sides; some run without any gaps.
            tx_gap_on   = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(4, 12)) send_query($urandom_range(1, 8), 10);
            // Sometimes leave a query open across the next ray load.
            if ($urandom_range(0, 2) == 0) send_box(near_ray_box(1'b0));
            phase++;
        end
    endtask

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ORIGIN_X;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_box_min_x = '0;
        i_box_min_y = '0;
        i_box_min_z = '0;
        i_box_max_x = '0;
        i_box_max_y = '0;
        i_box_max_z = '0;
        i_object_id = '0;
        i_skip_box  = 1'b0;
        i_last_box  = 1'b0;
        reset_ray_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_ray();
        test_ray_registers();
        test_burst_and_drain();
        test_random_queries();

        drain_results();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ ray_box_slab_nearest_hit.f @@
rtl/core/rbsn_pkg.sv
rtl/core/rbsn_cfg.sv
rtl/core/rbsn_front.sv
rtl/core/rbsn_queue.sv
rtl/core/rbsn_back.sv
rtl/core/ray_box_slab_nearest_hit.sv
tb/testbench.sv
